// ===== rtl/core/utd_pkg.sv =====
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types, codes and helpers for the request target decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEquals  = 8'h3D;

  typedef enum logic [1:0] {
    MODE_PATH  = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_VALUE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    HEX_NONE = 2'd0,
    HEX_HI   = 2'd1,
    HEX_LO   = 2'd2
  } hex_phase_e;

  typedef enum logic [2:0] {
    KIND_PATH     = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_PAIR_END = 3'd3,
    KIND_STATUS   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // Parser state carried from item to item.
  typedef struct packed {
    mode_e      mode;
    hex_phase_e phase;
    logic [3:0] accum;   // high nibble of a pending escape
    logic       done;
    logic       err;
  } state_t;

  // One result item; valid low means the byte produced nothing.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_e      kind;
    status_e    status;
  } result_t;

  localparam state_t StateReset = '{
    mode:  MODE_PATH,
    phase: HEX_NONE,
    accum: 4'd0,
    done:  1'b0,
    err:   1'b0
  };

  // Hex digit check: {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utd_step.sv =====
// ----------------------------------------------------------------------------
// utd_step
// Next state and result for one raw byte of the request target.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_step (
  input  var utd_pkg::state_t  state_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            start_req_i,
  output utd_pkg::state_t      state_o,
  output utd_pkg::result_t     result_o
);

  utd_pkg::state_t  cur;
  utd_pkg::kind_e   data_kind;
  logic [4:0]       hex;

  assign hex = utd_pkg::hex_digit(in_byte_i);

  always_comb begin
    cur = start_req_i ? utd_pkg::StateReset : state_i;

    unique case (cur.mode)
      utd_pkg::MODE_PATH: data_kind = utd_pkg::KIND_PATH;
      utd_pkg::MODE_KEY:  data_kind = utd_pkg::KIND_KEY;
      default:            data_kind = utd_pkg::KIND_VALUE;
    endcase

    state_o         = cur;
    result_o.valid  = 1'b0;
    result_o.data   = 8'd0;
    result_o.kind   = utd_pkg::KIND_STATUS;
    result_o.status = utd_pkg::ST_BUSY;

    if (cur.done || cur.err) begin
      // stopped: swallow bytes until start
    end else if (cur.phase != utd_pkg::HEX_NONE) begin
      if (!hex[4]) begin
        state_o.err     = 1'b1;
        state_o.phase   = utd_pkg::HEX_NONE;
        result_o.valid  = 1'b1;
        result_o.status = utd_pkg::ST_ERR;
      end else if (cur.phase == utd_pkg::HEX_HI) begin
        state_o.accum = hex[3:0];
        state_o.phase = utd_pkg::HEX_LO;
      end else begin
        state_o.phase  = utd_pkg::HEX_NONE;
        state_o.accum  = 4'd0;
        result_o.valid = 1'b1;
        result_o.data  = {cur.accum, hex[3:0]};
        result_o.kind  = data_kind;
      end
    end else if (in_byte_i == utd_pkg::ChPercent) begin
      state_o.phase = utd_pkg::HEX_HI;
      state_o.accum = 4'd0;
    end else if (cur.mode == utd_pkg::MODE_PATH) begin
      if (in_byte_i == utd_pkg::ChQuery) begin
        state_o.mode = utd_pkg::MODE_KEY;
      end else if (in_byte_i == utd_pkg::ChSpace) begin
        state_o.done    = 1'b1;
        result_o.valid  = 1'b1;
        result_o.status = utd_pkg::ST_DONE;
      end else begin
        result_o.valid = 1'b1;
        result_o.kind  = utd_pkg::KIND_PATH;
        result_o.data  = (in_byte_i == utd_pkg::ChPlus) ? utd_pkg::ChSpace : in_byte_i;
      end
    end else begin
      if (in_byte_i == utd_pkg::ChSpace) begin
        state_o.done    = 1'b1;
        state_o.mode    = utd_pkg::MODE_KEY;
        result_o.valid  = 1'b1;
        result_o.kind   = utd_pkg::KIND_PAIR_END;
        result_o.status = utd_pkg::ST_DONE;
      end else if (in_byte_i == utd_pkg::ChAmp) begin
        state_o.mode   = utd_pkg::MODE_KEY;
        result_o.valid = 1'b1;
        result_o.kind  = utd_pkg::KIND_PAIR_END;
      end else if (in_byte_i == utd_pkg::ChEquals) begin
        state_o.mode = utd_pkg::MODE_VALUE;
      end else begin
        result_o.valid = 1'b1;
        result_o.kind  = data_kind;
        result_o.data  = in_byte_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/url_target_decoder_core.sv =====
// ----------------------------------------------------------------------------
// url_target_decoder_core
// Streaming percent decoder for the target of an HTTP request line.
// ----------------------------------------------------------------------------
// Raw target bytes go in one per clock and come out as tagged items: path,
// key and value bytes, pair ends, and status-only items for a path finish or
// a bad escape digit. The parser state register and the combinational step
// logic close the loop from one byte to the next, and the registered result
// shows on the output in the cycle after the byte is
// accepted. Bytes that produce nothing ('%', the first hex digit, '?' in the
// path, '=' in the query, anything while stopped) give no item. The input
// stalls only while a held result is itself stalled, so with a free-running
// sink the rate is one byte per clock. After a finish or a format error the
// parser ignores bytes until one arrives with start_req_i set.
// ----------------------------------------------------------------------------
`default_nettype none

module url_target_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // raw byte channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_req_i,
  // decoded item channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      kind_o,
  output logic [1:0]      status_o
);

  utd_pkg::state_t  state_q, state_d;
  utd_pkg::result_t res;
  logic             accept;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  utd_pkg::kind_e   kind_q;
  utd_pkg::status_e status_q;

  // The output register frees up the same cycle its item is taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  utd_step u_step (
    .state_i     (state_q),
    .in_byte_i   (in_byte_i),
    .start_req_i (start_req_i),
    .state_o     (state_d),
    .result_o    (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utd_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_byte_q <= res.data;
      kind_q     <= res.kind;
      status_q   <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;

`ifndef ASSERT_OFF
  // Finish and error never stand together.
  a_done_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.done && state_q.err))
    else $error("done and error flags both set");

  // An error item leaves the parser stopped on error.
  a_err_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.valid && res.status == utd_pkg::ST_ERR) |=> state_q.err)
    else $error("error item without error flag");

  // Data byte kinds always report in progress.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == utd_pkg::KIND_PATH || kind_o == utd_pkg::KIND_KEY ||
                     kind_o == utd_pkg::KIND_VALUE)) |-> status_o == utd_pkg::ST_BUSY)
    else $error("data item with non-busy status");

  // Items without a byte carry zero and a status-only item reports a stop.
  a_nobyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == utd_pkg::KIND_PAIR_END || kind_o == utd_pkg::KIND_STATUS))
      |-> (out_byte_o == 8'd0 &&
           (kind_o != utd_pkg::KIND_STATUS || status_o != utd_pkg::ST_BUSY)))
    else $error("bad byte-less item");
`endif

endmodule

`default_nettype wire

// ===== dv/url_target_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// url_target_decoder_core_tb
// Self-checking bench for the streaming request target decoder.
// ----------------------------------------------------------------------------
// Raw target bytes are pushed through the input channel. Each accepted byte
// also runs through a local model of the parser, and the decoded item it
// should produce, if any, is queued. Every item leaving the block is checked
// field by field against the oldest queued item. A few directed targets come
// first (path, query, bad escapes, restart). Random targets follow, mostly
// well formed with random content, with some noise, broken escapes and bytes
// sent to a stopped parser. Both sides idle and stall in short random bursts,
// except in the last stretch of the run.
// ----------------------------------------------------------------------------

module url_target_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utd_pkg::*;

  localparam int WatchdogLimit = 2000;  // cycles with no item moved on either side
  localparam int DrainCycles   = 10;    // margin after the last queued item is taken
  localparam int RandomItems   = 900;   // live bytes in the random part
  localparam int QuietTail     = 150;   // last live bytes run without idling

  // One decoded item as seen on the output channel.
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    status_e    status;
  } dec_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       start_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [2:0] kind_o;
  logic [1:0] status_o;

  // Items the block still owes us, oldest first.
  dec_item_t  decoded_q[$];

  // Local copy of the parser state.
  mode_e      cur_mode;
  hex_phase_e esc_phase;
  logic [3:0] esc_hi;
  bit         tgt_done;
  bit         tgt_err;

  int         errors;
  int         live_items;   // bytes the parser actually acted on
  bit         src_idle;     // random gaps on the byte side
  bit         sink_idle;    // random stalls on the item side
  bit         start_pend;   // next byte sent carries start_req

  url_target_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  // Digit value 0..15, or 16 for anything that is not a hex digit.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return 16;
  endfunction

  function automatic kind_e data_kind(input mode_e m);
    if (m == MODE_PATH) return KIND_PATH;
    if (m == MODE_KEY) return KIND_KEY;
    return KIND_VALUE;
  endfunction

  task automatic clear_parser();
    cur_mode  = MODE_PATH;
    esc_phase = HEX_NONE;
    esc_hi    = 4'd0;
    tgt_done  = 1'b0;
    tgt_err   = 1'b0;
  endtask

  task automatic queue_item(input logic [7:0] d, input kind_e k, input status_e s);
    dec_item_t it;
    it.data   = d;
    it.kind   = k;
    it.status = s;
    decoded_q = {decoded_q, it};
  endtask

  // Advance the model by one accepted byte. live is low when a stopped
  // parser just drops the byte.
  task automatic decode_byte(input logic [7:0] b, input logic st, output bit live);
    int d;
    if (st) clear_parser();
    live = !(tgt_done || tgt_err);
    if (live) begin
      if (esc_phase != HEX_NONE) begin
        // inside an escape every byte is a digit candidate
        d = hex_val(b);
        if (d > 15) begin
          tgt_err   = 1'b1;
          esc_phase = HEX_NONE;
          queue_item(8'd0, KIND_STATUS, ST_ERR);
        end else if (esc_phase == HEX_HI) begin
          esc_hi    = d[3:0];
          esc_phase = HEX_LO;
        end else begin
          esc_phase = HEX_NONE;
          queue_item({esc_hi, d[3:0]}, data_kind(cur_mode), ST_BUSY);
          esc_hi = 4'd0;
        end
      end else if (b == ChPercent) begin
        esc_phase = HEX_HI;
        esc_hi    = 4'd0;
      end else if (cur_mode == MODE_PATH) begin
        if (b == ChPlus) begin
          queue_item(ChSpace, KIND_PATH, ST_BUSY);
        end else if (b == ChQuery) begin
          cur_mode = MODE_KEY;
        end else if (b == ChSpace) begin
          tgt_done = 1'b1;
          queue_item(8'd0, KIND_STATUS, ST_DONE);
        end else begin
          queue_item(b, KIND_PATH, ST_BUSY);
        end
      end else begin
        // query part: key or value
        if (b == ChSpace) begin
          tgt_done = 1'b1;
          cur_mode = MODE_KEY;
          queue_item(8'd0, KIND_PAIR_END, ST_DONE);
        end else if (b == ChAmp) begin
          cur_mode = MODE_KEY;
          queue_item(8'd0, KIND_PAIR_END, ST_BUSY);
        end else if (b == ChEquals) begin
          cur_mode = MODE_VALUE;
        end else begin
          queue_item(b, data_kind(cur_mode), ST_BUSY);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------

  // Entered and left at a falling edge. Payload holds until the byte is
  // taken; in_stall_o is read right after the rising edge, so it still shows
  // the value that decided acceptance.
  task automatic send_byte(input logic [7:0] b, input logic st);
    logic st_eff;
    bit   live;
    st_eff     = st | start_pend;
    start_pend = 1'b0;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    start_req_i <= st_eff;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, st_eff, live);
    if (live) live_items++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + n;
    if (lower) return "a" + (n - 4'd10);
    return "A" + (n - 4'd10);
  endfunction

  // Any byte that is not one of the parser's control characters.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == ChPercent || b == ChPlus || b == ChQuery || b == ChSpace ||
               b == ChAmp || b == ChEquals);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (hex_val(b) < 16);
    return b;
  endfunction

  task automatic send_escape();
    send_byte(ChPercent, 1'b0);
    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
  endtask

  // One character of path, key or value text.
  task automatic send_text(input bit in_query, input bit allow_eq);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) send_escape();
    else if (r == 2) send_byte(ChPlus, 1'b0);
    else if (r == 3 && in_query) send_byte(ChQuery, 1'b0);
    else if (r == 4 && allow_eq) send_byte(ChEquals, 1'b0);
    else send_byte(plain_byte(), 1'b0);
  endtask

  // A well-formed target: path, optional query of key=value pairs, and
  // usually the closing space. The first byte carries start_req.
  task automatic send_target();
    int npairs;
    start_pend = 1'b1;
    repeat ($urandom_range(1, 10)) send_text(1'b0, 1'b0);
    if ($urandom_range(0, 2) != 0) begin
      send_byte(ChQuery, 1'b0);
      npairs = $urandom_range(1, 3);
      for (int p = 0; p < npairs; p++) begin
        repeat ($urandom_range(0, 5)) send_text(1'b1, 1'b0);
        if ($urandom_range(0, 3) != 0) begin
          send_byte(ChEquals, 1'b0);
          repeat ($urandom_range(0, 5)) send_text(1'b1, 1'b1);
        end
        if (p != npairs - 1) send_byte(ChAmp, 1'b0);
      end
    end
    // an unterminated target is simply cut off by the next start
    if ($urandom_range(0, 9) != 0) send_byte(ChSpace, 1'b0);
  endtask

  // Raw noise, broken escapes, and bytes thrown at a stopped parser.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
        end
      end
      1: begin
        send_byte(ChPercent, 1'b1);
        if ($urandom_range(0, 1) != 0) begin
          send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        end
        send_byte(non_hex_byte(), 1'b0);
      end
      default: begin
        send_byte(ChSpace, 1'b1);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Item side
  // --------------------------------------------------------------------------

  // Random stall bursts, changed at falling edges only.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  mismatch: %s  got 0x%0h  want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Each item taken from the block is compared with the oldest queued one.
  always @(posedge clk_i) begin
    dec_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("item with nothing queued", {out_byte_o, kind_o, status_o}, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
        if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Path bytes, '+', byte extremes, escapes in both letter cases, finish,
  // a dropped byte after finish, then restart.
  task automatic test_path_basics();
    send_byte("/", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChPlus, 1'b0);
    send_byte(ChPercent, 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b0);
    send_byte(ChPercent, 1'b0);
    send_byte("f", 1'b0);
    send_byte("F", 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte("x", 1'b0);        // stopped: no item
    send_byte("y", 1'b1);
  endtask

  // Query: key, '=', a second '=' (no item), value holding '?' and '+', pair
  // end, an escape in a key, and the closing space.
  task automatic test_query_pairs();
    send_byte(ChQuery, 1'b1);
    send_byte("k", 1'b0);
    send_byte(ChEquals, 1'b0);
    send_byte(ChEquals, 1'b0);
    send_byte(ChQuery, 1'b0);
    send_byte(ChPlus, 1'b0);
    send_byte(ChAmp, 1'b0);
    send_byte(ChPercent, 1'b0);
    send_byte("3", 1'b0);
    send_byte("d", 1'b0);
    send_byte(ChSpace, 1'b0);
  endtask

  // Bad digits just outside the hex ranges, '%' as a digit, and a space
  // that finishes right on the start byte.
  task automatic test_bad_escapes();
    send_byte(ChPercent, 1'b1);
    send_byte(":", 1'b0);
    send_byte("z", 1'b0);        // stopped after error
    send_byte(ChPercent, 1'b1);
    send_byte("a", 1'b0);
    send_byte("G", 1'b0);
    send_byte(ChPercent, 1'b1);
    send_byte(ChPercent, 1'b0);
    send_byte(ChSpace, 1'b1);
  endtask

  task automatic test_random_targets();
    live_items = 0;
    while (live_items < RandomItems) begin
      if (live_items > RandomItems - QuietTail) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_target();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'd0;
    start_req_i = 1'b0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    start_pend  = 1'b0;
    errors      = 0;
    live_items  = 0;
    clear_parser();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_path_basics();
    test_query_pairs();
    test_bad_escapes();
    test_random_targets();

    in_valid_i <= 1'b0;
    // the watchdog bounds this wait
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
